### rtl/julia_escape_time_defines.svh
// Assertion macros for the Julia escape-time block.
// Used by julia_escape_time.sv; expects clk_i and rst_ni in scope.
`ifndef JULIA_ESCAPE_TIME_DEFINES_SVH
`define JULIA_ESCAPE_TIME_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jet_pkg.sv
// Shared constants and helpers for the Julia escape-time block.
// No dependencies; imported by julia_escape_time.
`default_nettype none

package jet_pkg;

  localparam int unsigned FracBits = 28;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // |z|^2 threshold 4.0 in Q8.56
  localparam logic [63:0] EscapeMag = 64'h0400_0000_0000_0000;

  localparam logic [CfgIdxW-1:0] RegCReal   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCImag   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepRe  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepIm  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxIter = 3'd4;

  // Clamp a 48-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic hi_same;
    hi_same = (v[47:31] == {17{v[47]}});
    if (hi_same) begin
      return v[31:0];
    end else if (v[47]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/julia_escape_time.sv
// Julia-set escape-time engine, signed Q4.28, one shared 32x32 multiplier.
// Depends on jet_pkg and julia_escape_time_defines.svh.
//
// Usage:
//   A transaction is accepted at a rising edge with start_i high and busy_o
//   low; pixel_x_i, pixel_y_i, origin_real_i and origin_imag_i are sampled
//   then. busy_o stays high while the point is worked on.
//   The result appears on iterations_o for exactly one cycle with done_o
//   high; the receiver cannot stall it. busy_o is low in that cycle, so the
//   next transaction may be accepted at its closing edge.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write one register per
//   edge (0 c_real, 1 c_imag, 2 step_real, 3 step_imag, 4 max_iter); other
//   indexes are ignored. Write only while busy_o is low.
//   Setup runs ST_MUL_RE, ST_MUL_IM and ST_SET_IM; each iteration runs
//   ST_MUL_RR, ST_MUL_II, ST_MUL_RI and ST_UPDATE. The point ends in ST_MUL_RR
//   at the limit or in ST_MUL_RI on escape; no new transaction is accepted
//   before then. Each iteration runs re*re, im*im and re*im through the multiplier.
//   Reset: asynchronous, active low; returns to idle and loads the default
//   register values. No memories, so no clearing pass.
`default_nettype none
`include "julia_escape_time_defines.svh"

module julia_escape_time
  import jet_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input  wire logic [COORD_BITS-1:0]         pixel_x_i,
  input  wire logic [COORD_BITS-1:0]         pixel_y_i,
  input  wire logic signed [31:0]            origin_real_i,
  input  wire logic signed [31:0]            origin_imag_i,
  output      logic                          done_o,
  output      logic [7:0]                    iterations_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [CfgIdxW-1:0]            cfg_idx_i,
  input  wire logic [CfgDataW-1:0]           cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RE,
    ST_MUL_IM,
    ST_SET_IM,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE
  } state_e;

  state_e state_q;

  logic signed [30:0] c_re_q, c_im_q;
  logic signed [28:0] step_re_q, step_im_q;
  logic [7:0]         max_iter_q;

  logic [COORD_BITS-1:0] px_q, py_q;
  logic signed [31:0]    ore_q, oim_q;
  logic signed [31:0]    re_q, im_q;
  logic signed [63:0]    prod_q, rr_q, diff_q;
  logic [7:0]            cnt_q;
  logic                  done_q;
  logic [7:0]            iter_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;
  logic [63:0]        mag;
  logic signed [31:0] re_start, im_start, re_next, im_next;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_RE: begin
        mul_a = 32'(step_re_q);
        mul_b = $signed({{(32-COORD_BITS){1'b0}}, px_q});
      end
      ST_MUL_IM: begin
        mul_a = 32'(step_im_q);
        mul_b = $signed({{(32-COORD_BITS){1'b0}}, py_q});
      end
      ST_MUL_RR: begin
        mul_a = re_q;
        mul_b = re_q;
      end
      ST_MUL_II: begin
        mul_a = im_q;
        mul_b = im_q;
      end
      ST_MUL_RI: begin
        mul_a = re_q;
        mul_b = im_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign mag    = rr_q + prod_q;

  assign re_start = sat48($signed({{16{ore_q[31]}}, ore_q}) + $signed(prod_q[47:0]));
  assign im_start = sat48($signed({{16{oim_q[31]}}, oim_q}) + $signed(prod_q[47:0]));

  assign re_next = sat48($signed({{12{diff_q[63]}}, diff_q[63:FracBits]})
                       + $signed({{17{c_re_q[30]}}, c_re_q}));
  assign im_next = sat48($signed({{11{prod_q[63]}}, prod_q[63:FracBits-1]})
                       + $signed({{17{c_im_q[30]}}, c_im_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      cnt_q      <= '0;
      c_re_q     <= -31'sd107374182;
      c_im_q     <= 31'sd161061274;
      step_re_q  <= 29'sd1342177;
      step_im_q  <= -29'sd1230329;
      max_iter_q <= 8'd60;
    end else begin
      done_q <= 1'b0;
      prod_q <= prod_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCReal:   c_re_q     <= cfg_data_i[30:0];
          RegCImag:   c_im_q     <= cfg_data_i[30:0];
          RegStepRe:  step_re_q  <= cfg_data_i[28:0];
          RegStepIm:  step_im_q  <= cfg_data_i[28:0];
          RegMaxIter: max_iter_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            px_q    <= pixel_x_i;
            py_q    <= pixel_y_i;
            ore_q   <= origin_real_i;
            oim_q   <= origin_imag_i;
            state_q <= ST_MUL_RE;
          end
        end
        ST_MUL_RE: begin
          state_q <= ST_MUL_IM;
        end
        ST_MUL_IM: begin
          re_q    <= re_start;
          state_q <= ST_SET_IM;
        end
        ST_SET_IM: begin
          im_q    <= im_start;
          cnt_q   <= '0;
          state_q <= ST_MUL_RR;
        end
        ST_MUL_RR: begin
          if (cnt_q == max_iter_q) begin
            done_q  <= 1'b1;
            iter_q  <= cnt_q;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_MUL_II;
          end
        end
        ST_MUL_II: begin
          rr_q    <= prod_q;
          state_q <= ST_MUL_RI;
        end
        ST_MUL_RI: begin
          diff_q <= rr_q - prod_q;
          if (mag >= EscapeMag) begin
            done_q  <= 1'b1;
            iter_q  <= cnt_q;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          re_q    <= re_next;
          im_q    <= im_next;
          cnt_q   <= cnt_q + 8'd1;
          state_q <= ST_MUL_RR;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign iterations_o = iter_q;

  `JET_ASSERT_NOW(a_count_in_limit, done_o, iterations_o <= max_iter_q,
                  "iteration count above limit")
  `JET_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o,
                   "accepted transaction did not raise busy")
  `JET_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held over two cycles")
  `JET_ASSERT_NOW(a_update_below_limit, state_q == ST_UPDATE, cnt_q < max_iter_q,
                  "update step past iteration limit")

endmodule

`default_nettype wire
